@@ sv/cmdlf_pkg.sv @@
// cmdlf_pkg: shared types and constants for the command line framer
// used by cmdlf_ctrl, cmdlf_bank_ram and command_line_framer_top; no dependencies
package cmdlf_pkg;

	localparam int BANK_BYTES = 128;
	localparam int ADDR_W = $clog2(2 * BANK_BYTES);
	localparam int FILL_W = $clog2(BANK_BYTES);
	localparam int CMP_W = (FILL_W > 7) ? FILL_W : 7;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] MARKER_RESET = 8'd62;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_LOCK    = 2'd1,
		KIND_READ    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_DONE = 3'd1,
		EV_NOCR = 3'd2,
		EV_OVER = 3'd3,
		EV_BUSY = 3'd4
	} event_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		event_t     ev;
		logic       ready;
		logic [6:0] length;
		logic       data_hit;
	} result_t;

endpackage

@@ sv/cmdlf_bank_ram.sv @@
// cmdlf_bank_ram: two-bank line buffer, one write and one registered read per cycle
// depends on cmdlf_pkg
module cmdlf_bank_ram (
	input  logic                clk,
	input  cmdlf_pkg::mem_req_t req,
	output logic [7:0]          rd_data
);
	import cmdlf_pkg::*;

	logic [7:0] mem_q [2*BANK_BYTES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

@@ sv/cmdlf_ctrl.sv @@
// cmdlf_ctrl: framing state and per-transaction update, builds memory requests and result
// depends on cmdlf_pkg
module cmdlf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cmdlf_pkg::kind_t    kind,
	input  logic [7:0]          rx_byte,
	input  logic [6:0]          read_index,
	input  logic [7:0]          start_marker,
	output cmdlf_pkg::mem_req_t req,
	output cmdlf_pkg::result_t  res
);
	import cmdlf_pkg::*;

	logic              bank_q, bank_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              coll_q, coll_n;
	logic [7:0]        last_q, last_n;
	logic              ready_q, ready_n;
	logic              hold_q, hold_n;
	logic [FILL_W-1:0] ulen_q, ulen_n;

	logic [FILL_W:0]   fill_inc;
	logic              opens;
	event_t            ev;
	logic [ADDR_W-1:0] bank_base;
	logic [ADDR_W-1:0] user_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			fill_q  <= '0;
			coll_q  <= 1'b0;
			last_q  <= 8'd0;
			ready_q <= 1'b0;
			hold_q  <= 1'b0;
			ulen_q  <= '0;
		end else if (accept) begin
			bank_q  <= bank_n;
			fill_q  <= fill_n;
			coll_q  <= coll_n;
			last_q  <= last_n;
			ready_q <= ready_n;
			hold_q  <= hold_n;
			ulen_q  <= ulen_n;
		end
	end

	assign fill_inc  = {1'b0, fill_q} + 1'b1;
	assign opens     = coll_q || (rx_byte == start_marker);
	assign bank_base = bank_q ? ADDR_W'(BANK_BYTES) : '0;
	assign user_base = bank_q ? '0 : ADDR_W'(BANK_BYTES);

	always_comb begin
		bank_n  = bank_q;
		fill_n  = fill_q;
		coll_n  = coll_q;
		last_n  = last_q;
		ready_n = ready_q;
		hold_n  = hold_q;
		ulen_n  = ulen_q;
		ev      = EV_NONE;

		req.wr_en   = 1'b0;
		req.wr_addr = bank_base + ADDR_W'(fill_q);
		req.wr_data = rx_byte;
		req.rd_en   = accept;
		req.rd_addr = user_base + ADDR_W'(read_index);

		case (kind)
			KIND_BYTE: begin
				if (coll_q && rx_byte == CH_LF) begin
					// LF closes the line whatever the marker is
					if (last_q == CH_CR) begin
						if (hold_q) begin
							ev = EV_BUSY;
						end else begin
							ulen_n  = fill_q - 1'b1;
							bank_n  = ~bank_q;
							ready_n = 1'b1;
							ev      = EV_DONE;
						end
					end else begin
						ev = EV_NOCR;
					end
					coll_n = 1'b0;
					fill_n = '0;
					last_n = 8'd0;
				end else if (opens) begin
					req.wr_en = accept;
					if (fill_inc > (FILL_W+1)'(BANK_BYTES - 2)) begin
						coll_n = 1'b0;
						fill_n = '0;
						last_n = 8'd0;
						ev     = EV_OVER;
					end else begin
						coll_n = 1'b1;
						fill_n = fill_inc[FILL_W-1:0];
						last_n = rx_byte;
					end
				end
			end
			KIND_LOCK: begin
				hold_n = 1'b1;
			end
			KIND_READ: begin
			end
			KIND_RELEASE: begin
				hold_n  = 1'b0;
				ready_n = 1'b0;
			end
			default: begin
			end
		endcase

		res.ev       = ev;
		res.ready    = ready_n;
		res.length   = 7'(ulen_n);
		res.data_hit = (kind == KIND_READ) && (CMP_W'(read_index) < CMP_W'(ulen_q));
	end

endmodule

@@ sv/command_line_framer_top.sv @@
// command_line_framer_top: frames marker-opened, CR LF closed command lines into a double buffer
// depends on cmdlf_pkg, cmdlf_ctrl, cmdlf_bank_ram
//
//   channel  handshake            payload
//   in       in_valid / in_ready  kind, rx_byte, read_index
//   out      out_valid/out_ready  event_res, line_ready, line_length, read_data
//   cfg      cfg_valid/cfg_ready  cfg_data (start marker)
//
// one transaction per cycle while in_ready is high: state updates and the bank read happen at the accept edge,
// the result shows in the cycle after from the output register
// in_ready drops only while a result sits unread and out_ready is low
// no clearing pass after reset: bank reads are limited to the stored line length
// cfg is always ready; the start marker resets to '>'
module command_line_framer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] rx_byte,
	input  logic [6:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic       line_ready,
	output logic [6:0] line_length,
	output logic [7:0] read_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import cmdlf_pkg::*;

	logic       accept;
	logic [7:0] marker_q;
	mem_req_t   req;
	result_t    res;
	logic [7:0] ram_data;
	logic       out_valid_q;
	event_t     ev_q;
	logic       ready_q;
	logic [6:0] length_q;
	logic       hit_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_valid) begin
			marker_q <= cfg_data;
		end
	end

	cmdlf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (kind_t'(kind)),
		.rx_byte      (rx_byte),
		.read_index   (read_index),
		.start_marker (marker_q),
		.req          (req),
		.res          (res)
	);

	cmdlf_bank_ram u_ram (
		.clk     (clk),
		.req     (req),
		.rd_data (ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q     <= res.ev;
			ready_q  <= res.ready;
			length_q <= res.length;
			hit_q    <= res.data_hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = ev_q;
	assign line_ready  = ready_q;
	assign line_length = length_q;
	// bytes beyond the line read as zero
	assign read_data   = hit_q ? ram_data : 8'd0;

endmodule
